// File: src/ctr_pkg.sv
// Shared types and constants for the centroid tracker core counter.
package ctr_pkg;

   localparam int MAX_TRACKS      = 64;
   localparam int COORD_FRAC_BITS = 4;

   localparam int IDX_W   = $clog2(MAX_TRACKS);
   localparam int LIM_W   = 8 + COORD_FRAC_BITS;
   localparam int LIM2_W  = 2 * LIM_W;
   localparam int D2_W    = 33;
   localparam int CORE_W  = 17 + COORD_FRAC_BITS;

   // x/3 = (x * RECIP3) >> RECIP3_SHIFT, exact for x below 2^17
   localparam logic [15:0] RECIP3       = 16'd43691;
   localparam int          RECIP3_SHIFT = 17;

   localparam logic [6:0]  COUNT_MAX    = 7'd127;
   localparam logic [21:0] AREA_SUM_MAX = 22'd4194303;

   localparam logic [2:0] CSR_AREA_LOW     = 3'd0;
   localparam logic [2:0] CSR_AREA_HIGH    = 3'd1;
   localparam logic [2:0] CSR_MATCH_RADIUS = 3'd2;
   localparam logic [2:0] CSR_LEFT_EDGE_X  = 3'd3;
   localparam logic [2:0] CSR_RIGHT_EDGE_X = 3'd4;

   localparam logic ACT_OBJECT = 1'b0;
   localparam logic ACT_EOF    = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] object_area;
      logic [15:0] centre_x;
      logic [15:0] centre_y;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        newly_counted;
      logic [15:0] track_id;
      logic        table_full;
      logic [6:0]  frame_count;
      logic [21:0] frame_area;
   } rsp_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        counted;
      logic [15:0] id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: src/centroid_tracker_core_counter.sv
// Top level: nearest-centroid tracker with core-region object counter.
// Objects arrive as words on req_ and each yields exactly one word on rsp_. An
// end-of-frame word or an object of zero area or outside the area window goes
// straight from the idle state, which takes the word, to the output state. An
// accepted object runs a sequencer around one shared 16x16 multiplier: after
// the word is taken come the setup steps (squared match limit, core region
// bounds), then for each table entry the read, dx squared, dy squared and
// compare, then the update and the output state, plus any wait for rsp_ready.
// The block takes no new word until the result has left.
// Track entries live in one RAM; the current and next-frame valid flags are
// flip-flops, so end of frame swaps tables at once.
module centroid_tracker_core_counter
   import ctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_LIM    = 10'b0000000010,
      ST_CORE1  = 10'b0000000100,
      ST_CORE2  = 10'b0000001000,
      ST_RD     = 10'b0000010000,
      ST_DIFF   = 10'b0000100000,
      ST_SQY    = 10'b0001000000,
      ST_ACC    = 10'b0010000000,
      ST_DECIDE = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] area_low_ff, area_high_ff;
   logic [7:0]  radius_ff;
   logic [11:0] left_ff, right_ff;

   logic [15:0] area_ff, cx_ff, cy_ff;
   logic [MAX_TRACKS-1:0] tval_ff, nval_ff;
   logic [15:0] next_id_ff;
   logic [6:0]  fcount_ff;
   logic [21:0] fsum_ff;
   rsp_type     rsp_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic [LIM2_W-1:0] lim2_ff;
   logic [10:0]       q1_ff;
   logic              in_core_ff;
   logic [15:0]       dy_ff, e_id_ff;
   logic              e_cnt_ff;
   logic [D2_W-1:0]   sum_ff;
   logic              best_ok_ff, best_cnt_ff, free_ok_ff;
   logic [IDX_W-1:0]  best_slot_ff, free_slot_ff;
   logic [D2_W-1:0]   best_d2_ff;
   logic [15:0]       best_id_ff;

   logic [15:0] op_a, op_b;
   logic [31:0] prod;
   logic        ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   entry_type   ram_wdata, ram_rdata;
   logic [ENTRY_W-1:0] ram_rbits;

   ctr_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .prod(prod));

   ctr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TRACKS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rbits)
   );
   assign ram_rdata = entry_type'(ram_rbits);

   // region geometry
   logic        span_neg;
   logic [11:0] span_abs;
   logic [LIM_W-1:0] lim;
   assign span_neg = right_ff < left_ff;
   assign span_abs = span_neg ? (left_ff - right_ff) : (right_ff - left_ff);
   assign lim      = {radius_ff, {COORD_FRAC_BITS{1'b0}}};

   logic [11:0] q2;
   logic signed [CORE_W-1:0] left_s, q1_s, q2_s, lo_s, hi_s, px_s;
   assign q2     = prod[RECIP3_SHIFT +: 12];
   assign left_s = $signed(CORE_W'(left_ff));
   assign q1_s   = span_neg ? -$signed(CORE_W'(q1_ff)) : $signed(CORE_W'(q1_ff));
   assign q2_s   = span_neg ? -$signed(CORE_W'(q2)) : $signed(CORE_W'(q2));
   assign lo_s   = (left_s + q1_s) <<< COORD_FRAC_BITS;
   assign hi_s   = (left_s + q2_s) <<< COORD_FRAC_BITS;
   assign px_s   = $signed(CORE_W'(cx_ff));

   logic [15:0] dx, dy;
   assign dx = (ram_rdata.x >= cx_ff) ? (ram_rdata.x - cx_ff) : (cx_ff - ram_rdata.x);
   assign dy = (ram_rdata.y >= cy_ff) ? (ram_rdata.y - cy_ff) : (cy_ff - ram_rdata.y);

   logic [D2_W-1:0] d2;
   logic            last, take;
   assign d2   = sum_ff + D2_W'(prod);
   assign last = idx_ff == IDX_W'(MAX_TRACKS - 1);
   assign take = tval_ff[idx_ff] && (d2 < D2_W'(lim2_ff)) &&
                 (!best_ok_ff || d2 < best_d2_ff ||
                  (d2 == best_d2_ff && e_id_ff < best_id_ff));

   // decision
   logic             d_full, d_new, d_cnt, d_now;
   logic [IDX_W-1:0] d_slot;
   logic [15:0]      d_id;
   always_comb begin
      d_full = 1'b0;
      d_new  = 1'b0;
      d_slot = best_slot_ff;
      d_id   = best_id_ff;
      d_cnt  = best_cnt_ff;
      priority if (best_ok_ff) begin
      end else if (free_ok_ff) begin
         d_new  = 1'b1;
         d_slot = free_slot_ff;
         d_id   = next_id_ff;
         d_cnt  = 1'b0;
      end else begin
         d_full = 1'b1;
      end
      d_now = !d_full && in_core_ff && !d_cnt;
   end

   logic [22:0] sum_wide;
   assign sum_wide = {1'b0, fsum_ff} + 23'(area_ff);

   logic area_pass;
   assign area_pass = (req_data.object_area != 16'd0) &&
                      (req_data.object_area >= area_low_ff) &&
                      (req_data.object_area <= area_high_ff);

   always_comb begin
      op_a      = 16'd0;
      op_b      = 16'd0;
      ram_raddr = idx_ff;
      ram_we    = 1'b0;
      ram_waddr = d_slot;
      ram_wdata = '{x: cx_ff, y: cy_ff, counted: d_cnt | d_now, id: d_id};
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.action == ACT_OBJECT && area_pass) ? ST_LIM : ST_OUT;
            end
         end
         ST_LIM: begin
            op_a     = 16'(lim);
            op_b     = 16'(lim);
            state_in = ST_CORE1;
         end
         ST_CORE1: begin
            op_a     = 16'(span_abs);
            op_b     = RECIP3;
            state_in = ST_CORE2;
         end
         ST_CORE2: begin
            op_a     = 16'({span_abs, 1'b0});
            op_b     = RECIP3;
            state_in = ST_RD;
         end
         ST_RD: begin
            ram_raddr = '0;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            op_a     = dx;
            op_b     = dx;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            op_a     = dy_ff;
            op_b     = dy_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ram_raddr = idx_ff + IDX_W'(1);
            state_in  = last ? ST_DECIDE : ST_DIFF;
         end
         ST_DECIDE: begin
            ram_we   = !d_full;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         area_low_ff  <= 16'd100;
         area_high_ff <= 16'd40000;
         radius_ff    <= 8'd20;
         left_ff      <= 12'd0;
         right_ff     <= 12'd4095;
         tval_ff      <= '0;
         nval_ff      <= '0;
         next_id_ff   <= 16'd0;
         fcount_ff    <= 7'd0;
         fsum_ff      <= 22'd0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_AREA_LOW:     area_low_ff  <= csr_wdata;
               CSR_AREA_HIGH:    area_high_ff <= csr_wdata;
               CSR_MATCH_RADIUS: radius_ff    <= csr_wdata[7:0];
               CSR_LEFT_EDGE_X:  left_ff      <= csr_wdata[11:0];
               CSR_RIGHT_EDGE_X: right_ff     <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_valid && req_data.action == ACT_EOF) begin
            // next-frame table becomes the tracked one
            tval_ff   <= nval_ff;
            nval_ff   <= '0;
            fcount_ff <= 7'd0;
            fsum_ff   <= 22'd0;
         end
         if (state_ff == ST_DECIDE && !d_full) begin
            tval_ff[d_slot] <= 1'b1;
            nval_ff[d_slot] <= 1'b1;
            if (d_new) begin
               next_id_ff <= next_id_ff + 16'd1;
            end
            if (d_now) begin
               if (fcount_ff != COUNT_MAX) begin
                  fcount_ff <= fcount_ff + 7'd1;
               end
               fsum_ff <= (sum_wide > 23'(AREA_SUM_MAX)) ? AREA_SUM_MAX : sum_wide[21:0];
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            area_ff <= req_data.object_area;
            cx_ff   <= req_data.centre_x;
            cy_ff   <= req_data.centre_y;
            if (req_data.action == ACT_EOF) begin
               rsp_ff <= '{accepted: 1'b0, newly_counted: 1'b0, track_id: 16'd0,
                           table_full: 1'b0, frame_count: fcount_ff,
                           frame_area: fsum_ff};
            end else begin
               rsp_ff <= '0;
            end
         end
         ST_LIM: begin
            best_ok_ff <= 1'b0;
            free_ok_ff <= 1'b0;
            idx_ff     <= '0;
         end
         ST_CORE1: lim2_ff <= prod[LIM2_W-1:0];
         ST_CORE2: q1_ff   <= prod[RECIP3_SHIFT +: 11];
         ST_RD:    in_core_ff <= (px_s >= lo_s) && (px_s <= hi_s);
         ST_DIFF: begin
            dy_ff    <= dy;
            e_id_ff  <= ram_rdata.id;
            e_cnt_ff <= ram_rdata.counted;
         end
         ST_SQY: sum_ff <= D2_W'(prod);
         ST_ACC: begin
            if (take) begin
               best_ok_ff   <= 1'b1;
               best_slot_ff <= idx_ff;
               best_d2_ff   <= d2;
               best_id_ff   <= e_id_ff;
               best_cnt_ff  <= e_cnt_ff;
            end
            // remember the lowest free slot
            if (!tval_ff[idx_ff] && !free_ok_ff) begin
               free_ok_ff   <= 1'b1;
               free_slot_ff <= idx_ff;
            end
            idx_ff <= idx_ff + IDX_W'(1);
         end
         ST_DECIDE: begin
            rsp_ff.accepted      <= 1'b1;
            rsp_ff.newly_counted <= d_now;
            rsp_ff.track_id      <= d_full ? 16'd0 : d_id;
            rsp_ff.table_full    <= d_full;
            rsp_ff.frame_count   <= 7'd0;
            rsp_ff.frame_area    <= 22'd0;
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/ctr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ctr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ctr_mul.sv
// Shared registered 16x16 unsigned multiplier.
module ctr_mul
   import ctr_pkg::*;
(
   input  logic        clock,
   input  logic [15:0] op_a,
   input  logic [15:0] op_b,
   output logic [31:0] prod
);

   logic [31:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// File: dv/tb_centroid_tracker_core_counter.sv
// Testbench for the centroid tracker core counter: directed table, then random frames.
`timescale 1ns / 1ps

module tb_centroid_tracker_core_counter
   import ctr_pkg::*;
;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 3 * MAX_TRACKS + 20;
   localparam int N_ITEMS     = 1850;

   typedef struct {
      bit          valid;
      logic [15:0] x;
      logic [15:0] y;
      bit          counted;
      logic [15:0] id;
   } track_type;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   // tracker shadow state
   track_type   live_tracks [MAX_TRACKS];
   track_type   next_tracks [MAX_TRACKS];
   logic [15:0] next_id;
   int          n_counted;
   int          area_sum;
   int          cfg_area_low, cfg_area_high, cfg_radius, cfg_left, cfg_right;

   rsp_type     expected_rsp [$];
   row_type     rows [$];
   int          n_mismatch, n_sent, n_eof, n_full, n_new_count, idle_cycles;
   bit          failed, quiet, hold_rsp;
   int          scene_n;
   int          scene_x [16];
   int          scene_y [16];

   centroid_tracker_core_counter u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type track_word(req_type w);
      rsp_type r;
      longint  lft, span, lo, hi, lim2, dx, dy, d2, best_d2;
      int      best, slot;
      bit      in_core;
      r = '0;
      best = -1;
      slot = -1;
      best_d2 = 0;
      if (w.action == ACT_EOF) begin
         r.frame_count = n_counted[6:0];
         r.frame_area  = area_sum[21:0];
         live_tracks = next_tracks;
         foreach (next_tracks[i]) next_tracks[i] = '{default: '0};
         n_counted = 0;
         area_sum = 0;
         return r;
      end
      if (w.object_area == 0 || w.object_area < cfg_area_low || w.object_area > cfg_area_high)
         return r;
      lft = cfg_left;
      span = longint'(cfg_right) - lft;
      lo = (lft + span / 3) * (1 << COORD_FRAC_BITS);
      hi = (lft + (2 * span) / 3) * (1 << COORD_FRAC_BITS);
      in_core = (w.centre_x >= lo) && (w.centre_x <= hi);
      lim2 = longint'(cfg_radius << COORD_FRAC_BITS) * longint'(cfg_radius << COORD_FRAC_BITS);
      for (int i = 0; i < MAX_TRACKS; i++) begin
         if (!live_tracks[i].valid) continue;
         dx = longint'(live_tracks[i].x) - longint'(w.centre_x);
         dy = longint'(live_tracks[i].y) - longint'(w.centre_y);
         d2 = dx * dx + dy * dy;
         if (d2 >= lim2) continue;
         if (best < 0 || d2 < best_d2 ||
             (d2 == best_d2 && live_tracks[i].id < live_tracks[best].id)) begin
            best = i;
            best_d2 = d2;
         end
      end
      r.accepted = 1'b1;
      if (best >= 0) begin
         slot = best;
      end else begin
         for (int i = 0; i < MAX_TRACKS; i++)
            if (!live_tracks[i].valid && slot < 0) slot = i;
         if (slot < 0) begin
            r.table_full = 1'b1;
            n_full++;
            return r;
         end
         live_tracks[slot].valid = 1'b1;
         live_tracks[slot].counted = 1'b0;
         live_tracks[slot].id = next_id;
         next_id++;
      end
      live_tracks[slot].x = w.centre_x;
      live_tracks[slot].y = w.centre_y;
      if (in_core && !live_tracks[slot].counted) begin
         live_tracks[slot].counted = 1'b1;
         r.newly_counted = 1'b1;
         n_new_count++;
         if (n_counted < COUNT_MAX) n_counted++;
         area_sum += w.object_area;
         if (area_sum > AREA_SUM_MAX) area_sum = AREA_SUM_MAX;
      end
      next_tracks[slot] = live_tracks[slot];
      r.track_id = live_tracks[slot].id;
      return r;
   endfunction

   // call at a rising edge; valid stays high on return unless a random gap dropped it
   task automatic push_word(input req_type w, input bit typed, input rsp_type typed_rsp);
      rsp_type r;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      r = track_word(w);
      expected_rsp.insert(expected_rsp.size(), typed ? typed_rsp : r);
      n_sent++;
      if (w.action == ACT_EOF) n_eof++;
      if (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it
   task automatic csr_write(input logic [2:0] idx, input int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      case (idx)
         CSR_AREA_LOW:     cfg_area_low  = val & 16'hFFFF;
         CSR_AREA_HIGH:    cfg_area_high = val & 16'hFFFF;
         CSR_MATCH_RADIUS: cfg_radius    = val & 8'hFF;
         CSR_LEFT_EDGE_X:  cfg_left      = val & 12'hFFF;
         CSR_RIGHT_EDGE_X: cfg_right     = val & 12'hFFF;
         default: ;
      endcase
   endtask

   task automatic set_all(input int lo, input int hi, input int rad, input int l, input int r);
      csr_write(CSR_AREA_LOW, lo);
      csr_write(CSR_AREA_HIGH, hi);
      csr_write(CSR_MATCH_RADIUS, rad);
      csr_write(CSR_LEFT_EDGE_X, l);
      csr_write(CSR_RIGHT_EDGE_X, r);
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_word(bit act, int area, int x, int y);
      req_type w;
      w.action = act;
      w.object_area = area[15:0];
      w.centre_x = x[15:0];
      w.centre_y = y[15:0];
      return w;
   endfunction

   function automatic void add_row(bit act, int area, int x, int y, bit typed,
                                   bit acc, bit cnt, int id, int fc, int fa);
      row_type row;
      row.word = make_word(act, area, x, y);
      row.typed = typed;
      row.rsp = '0;
      row.rsp.accepted = acc;
      row.rsp.newly_counted = cnt;
      row.rsp.track_id = id[15:0];
      row.rsp.frame_count = fc[6:0];
      row.rsp.frame_area = fa[21:0];
      rows.insert(rows.size(), row);
   endfunction

   // one frame: moving scene (random if big or empty) plus some noise words
   task automatic send_frame(input int max_objs);
      int jit, n, k, area;
      jit = (cfg_radius << COORD_FRAC_BITS) / 2 + 1;
      if ($urandom_range(99) < 30 && scene_n < 16) begin
         scene_x[scene_n] = $urandom_range(65535);
         scene_y[scene_n] = $urandom_range(65535);
         scene_n++;
      end
      if ($urandom_range(99) < 15 && scene_n > 0) scene_n--;
      n = $urandom_range(0, max_objs);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 10) begin
            push_word(make_word(ACT_OBJECT, $urandom, $urandom, $urandom), 0, '0);
            continue;
         end
         if (scene_n == 0 || max_objs > 16) begin
            push_word(make_word(ACT_OBJECT, $urandom_range(cfg_area_low, cfg_area_high),
                                $urandom_range(65535), $urandom_range(65535)), 0, '0);
            continue;
         end
         k = $urandom_range(scene_n - 1);
         scene_x[k] += $urandom_range(2 * jit) - jit;
         scene_y[k] += $urandom_range(2 * jit) - jit;
         if (scene_x[k] < 0) scene_x[k] = 0;
         if (scene_x[k] > 65535) scene_x[k] = 65535;
         if (scene_y[k] < 0) scene_y[k] = 0;
         if (scene_y[k] > 65535) scene_y[k] = 65535;
         area = (cfg_area_low <= cfg_area_high && $urandom_range(9) != 0) ?
                $urandom_range(cfg_area_low, cfg_area_high) : $urandom_range(65535);
         push_word(make_word(ACT_OBJECT, area, scene_x[k], scene_y[k]), 0, '0);
      end
      push_word(make_word(ACT_EOF, $urandom, $urandom, $urandom), 0, '0);
   endtask

   // response check and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     idle_cycles, expected_rsp.size());
            $display("== FAIL ==");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               failed = 1'b1;
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected rsp word %h", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.accepted !== want.accepted ||
                   rsp_data.newly_counted !== want.newly_counted ||
                   rsp_data.track_id !== want.track_id ||
                   rsp_data.table_full !== want.table_full ||
                   rsp_data.frame_count !== want.frame_count ||
                   rsp_data.frame_area !== want.frame_area) begin
                  failed = 1'b1;
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display({"rsp mismatch: acc %b/%b cnt %b/%b id %0d/%0d full %b/%b",
                               " fc %0d/%0d fa %0d/%0d (exp/got)"},
                              want.accepted, rsp_data.accepted,
                              want.newly_counted, rsp_data.newly_counted,
                              want.track_id, rsp_data.track_id,
                              want.table_full, rsp_data.table_full,
                              want.frame_count, rsp_data.frame_count,
                              want.frame_area, rsp_data.frame_area);
               end
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 24);
         end
      end
   end

   initial begin
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_AREA_LOW;
      csr_wdata = '0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      failed = 1'b0;
      n_mismatch = 0;
      n_sent = 0;
      n_eof = 0;
      n_full = 0;
      n_new_count = 0;
      idle_cycles = 0;
      scene_n = 0;
      foreach (live_tracks[i]) live_tracks[i] = '{default: '0};
      foreach (next_tracks[i]) next_tracks[i] = '{default: '0};
      next_id = '0;
      n_counted = 0;
      area_sum = 0;
      cfg_area_low = 100;
      cfg_area_high = 40000;
      cfg_radius = 20;
      cfg_left = 0;
      cfg_right = 4095;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: core region x in 21840..43680, radius 320 in 12.4
      add_row(ACT_OBJECT, 0,     32000, 0,     1, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 99,    32000, 0,     1, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 100,   32000, 0,     1, 1, 1, 0, 0, 0);
      add_row(ACT_OBJECT, 100,   32000, 0,     1, 1, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 40000, 65535, 65535, 1, 1, 0, 1, 0, 0);
      add_row(ACT_OBJECT, 40001, 0,     0,     1, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 65535, 0,     0,     1, 0, 0, 0, 0, 0);
      add_row(ACT_EOF,    0,     0,     0,     1, 0, 0, 0, 1, 100);
      add_row(ACT_OBJECT, 500,   21839, 100,   0, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 500,   21840, 5000,  0, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 500,   43680, 9000,  0, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 500,   43681, 13000, 0, 0, 0, 0, 0, 0);
      // two tracks equally far from the next object: lowest id takes it
      add_row(ACT_OBJECT, 600,   1000,  30000, 0, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 600,   1400,  30000, 0, 0, 0, 0, 0, 0);
      add_row(ACT_EOF,    0,     0,     0,     0, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 700,   1200,  30000, 0, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 700,   1200,  30319, 0, 0, 0, 0, 0, 0);
      add_row(ACT_OBJECT, 700,   1200,  30640, 0, 0, 0, 0, 0, 0);
      add_row(ACT_EOF,    0,     0,     0,     0, 0, 0, 0, 0, 0);
      add_row(ACT_EOF,    0,     0,     0,     0, 0, 0, 0, 0, 0);
      foreach (rows[i]) push_word(rows[i].word, rows[i].typed, rows[i].rsp);
      drain();

      phase = 0;
      while (n_sent < N_ITEMS) begin
         case (phase % 7)
            0: set_all(100, 40000, 20, 0, 4095);
            1: set_all(0, 65535, 255, 4095, 0);
            2: set_all(1, 65535, 0, 0, 4095);
            3: set_all($urandom_range(65535), $urandom_range(65535), $urandom_range(255),
                       $urandom_range(4095), $urandom_range(4095));
            4: set_all($urandom_range(2000), $urandom_range(20000, 65535),
                       $urandom_range(10, 60), $urandom_range(1000), $urandom_range(3000, 4095));
            5: set_all(65535, 65535, 1, 4095, 4095);
            default: set_all(0, 0, 128, 2048, 2047);
         endcase
         quiet = (phase == 4);
         for (int f = 0; f < 24 && n_sent < N_ITEMS; f++) begin
            if (phase == 1 && f == 5) hold_rsp = 1'b1;
            if (phase == 3 && f == 8) drain();
            // zero radius never matches, so big frames can overflow the table
            send_frame((phase % 7 == 2 && f % 3 == 0) ? 72 : 9);
         end
         drain();
         phase++;
      end

      quiet = 1'b0;
      $display("covered %0d words in %0d frames over %0d register settings", n_sent, n_eof,
               phase);
      $display("tracks counted %0d times, table overflow hit %0d times, %0d mismatches",
               n_new_count, n_full, n_mismatch);
      if (!failed && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
src/ctr_pkg.sv
src/ctr_ram.sv
src/ctr_mul.sv
src/centroid_tracker_core_counter.sv
dv/tb_centroid_tracker_core_counter.sv
